/* rtl/core/msh_pkg.sv */
// ----------------------------------------------------------------------------
// msh_pkg: shared types and float helpers
// Beat layout of the divider cells, special value tests, leading zero counts
// and the round-to-nearest-even pack used by the rounding stages.
// ----------------------------------------------------------------------------
package msh_pkg;

  localparam int unsigned NumCells   = 26;
  localparam logic [31:0] MagicReset = 32'h1FBB4F2D;
  localparam logic [31:0] QnanBits   = 32'h7FC00000;
  localparam logic [2:0]  AddrMagic  = 3'd0;

  typedef logic signed [9:0] sexp_t;

  typedef struct packed {
    logic        ovr;
    logic [31:0] bits;
  } ovr_t;

  typedef struct packed {
    logic [31:0] g;
    logic        spec;
    logic [31:0] spec_bits;
    ovr_t        ovr;
    logic        sgn;
    sexp_t       qexp;
    logic [23:0] mg;
    logic [25:0] rem;
    logic [25:0] quo;
  } div_beat_t;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hff) && (b[22:0] != 23'h0);
  endfunction

  function automatic logic is_inf(input logic [31:0] b);
    return (b[30:23] == 8'hff) && (b[22:0] == 23'h0);
  endfunction

  function automatic logic is_zero(input logic [31:0] b);
    return b[30:0] == 31'h0;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    logic       found;
    n     = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) begin
          found = 1'b1;
        end else begin
          n = n + 5'd1;
        end
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] m);
    logic [4:0] n;
    logic       found;
    n     = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) begin
          found = 1'b1;
        end else begin
          n = n + 5'd1;
        end
      end
    end
    return n;
  endfunction

  // mantissa has the hidden bit at 26 and guard, round, sticky at 2..0
  function automatic logic [31:0] round_pack(input logic sgn, input sexp_t e,
                                             input logic [26:0] m);
    logic [26:0] ms;
    logic [26:0] mask;
    logic [9:0]  sh;
    logic [7:0]  eb;
    logic        inc;
    logic [24:0] f;
    logic [30:0] body;
    ms   = m;
    mask = 27'h0;
    sh   = 10'h0;
    eb   = 8'h0;
    if (e > sexp_t'(254)) begin
      return {sgn, 8'hff, 23'h0};
    end
    if (e < sexp_t'(1)) begin
      sh = 10'(sexp_t'(1) - e);
      if (sh >= 10'd27) begin
        ms = {26'h0, |m};
      end else begin
        mask = (27'h1 << sh[4:0]) - 27'h1;
        ms   = (m >> sh[4:0]) | {26'h0, |(m & mask)};
      end
    end else begin
      eb = 8'(e - sexp_t'(1));
    end
    inc  = ms[2] & (ms[1] | ms[0] | ms[3]);
    f    = {1'b0, ms[26:3]} + {24'h0, inc};
    body = {eb, 23'h0} + {6'h0, f};
    return {sgn, body};
  endfunction

endpackage

/* rtl/core/msh_div_cell.sv */
// ----------------------------------------------------------------------------
// msh_div_cell: one restoring division step
// Compares the partial remainder with the divisor, retires one quotient bit
// and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module msh_div_cell
  import msh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  div_beat_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output div_beat_t data_o
);

  logic      valid_q;
  logic      en;
  logic      ge;
  logic [25:0] rem_n;
  div_beat_t data_d;
  div_beat_t data_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    ge          = data_i.rem >= {2'b00, data_i.mg};
    rem_n       = ge ? (data_i.rem - {2'b00, data_i.mg}) : data_i.rem;
    data_d      = data_i;
    data_d.rem  = {rem_n[24:0], 1'b0};
    data_d.quo  = {data_i.quo[24:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/msh_div_chain.sv */
// ----------------------------------------------------------------------------
// msh_div_chain: row of division cells
// One quotient bit per cell, so a quotient of hidden bit, fraction, guard
// and round bits leaves the last cell with its remainder for the sticky bit.
// ----------------------------------------------------------------------------
module msh_div_chain
  import msh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  div_beat_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output div_beat_t data_o
);

  logic      vld [NumCells+1];
  logic      rdy [NumCells+1];
  div_beat_t dat [NumCells+1];

  assign vld[0]        = valid_i;
  assign dat[0]        = data_i;
  assign ready_o       = rdy[0];
  assign rdy[NumCells] = ready_i;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    msh_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .data_i  (dat[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .data_o  (dat[k+1])
    );
  end

  assign valid_o = vld[NumCells];
  assign data_o  = dat[NumCells];

endmodule

/* rtl/core/magic_sqrt_heron_step.sv */
// ----------------------------------------------------------------------------
// magic_sqrt_heron_step: magic-number square root guess with one Heron step
// Guess from halved input bits plus a magic word, then 0.5 * (g + x / g)
// in single precision, round to nearest even, subnormals kept.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------
//   in       | in        | in_valid_i / in_stall_o    | value_bits_i
//   out      | out       | out_valid_o / out_stall_i  | root_bits_o
//   cfg      | in        | psel penable pwrite pready | magic_word
//
// one beat per cycle while out_stall_i is low
// a beat passes the 26 cell division row, then round, four add stages, halve
// reset empties every stage and loads magic_word with 0x1FBB4F2D
// a stall only holds stages that are full: bubbles close up behind it
// ----------------------------------------------------------------------------
module magic_sqrt_heron_step
  import msh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] root_bits_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [31:0] magic_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == AddrMagic[2]);
  assign prdata = (paddr[2] == AddrMagic[2]) ? magic_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MagicReset;
    end else if (cfg_wr) begin
      magic_q <= pwdata;
    end
  end

  // stage enables
  logic v_p0_q, v_p1_q, v_r1_q, v_a1_q, v_a2_q, v_a3_q, v_a4_q, v_h1_q, v_h2_q;
  logic en_p0, en_p1, en_r1, en_a1, en_a2, en_a3, en_a4, en_h1, en_h2;
  logic ch_ready, ch_valid;

  assign en_h2 = !v_h2_q || !out_stall_i;
  assign en_h1 = !v_h1_q || en_h2;
  assign en_a4 = !v_a4_q || en_h1;
  assign en_a3 = !v_a3_q || en_a4;
  assign en_a2 = !v_a2_q || en_a3;
  assign en_a1 = !v_a1_q || en_a2;
  assign en_r1 = !v_r1_q || en_a1;
  assign en_p1 = !v_p1_q || ch_ready;
  assign en_p0 = !v_p0_q || en_p1;

  assign in_stall_o = !en_p0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p0_q <= 1'b0;
      v_p1_q <= 1'b0;
      v_r1_q <= 1'b0;
      v_a1_q <= 1'b0;
      v_a2_q <= 1'b0;
      v_a3_q <= 1'b0;
      v_a4_q <= 1'b0;
      v_h1_q <= 1'b0;
      v_h2_q <= 1'b0;
    end else begin
      if (en_p0) v_p0_q <= in_valid_i;
      if (en_p1) v_p1_q <= v_p0_q;
      if (en_r1) v_r1_q <= ch_valid;
      if (en_a1) v_a1_q <= v_r1_q;
      if (en_a2) v_a2_q <= v_a1_q;
      if (en_a3) v_a3_q <= v_a2_q;
      if (en_a4) v_a4_q <= v_a3_q;
      if (en_h1) v_h1_q <= v_a4_q;
      if (en_h2) v_h2_q <= v_h1_q;
    end
  end

  // p0: operand and first guess
  logic [31:0] x0_q, g0_q;

  always_ff @(posedge clk_i) begin
    if (en_p0) begin
      x0_q <= value_bits_i;
      g0_q <= {value_bits_i[31], value_bits_i[31:1]} + magic_q;
    end
  end

  // p1: special cases and normalised mantissas
  div_beat_t   b1_d, b1_q;
  logic [23:0] mx1_d, mx1_q;
  sexp_t       ex1_d, ex1_q, eg1_d, eg1_q;
  logic [4:0]  lzx, lzg;
  logic        sx, sg;

  always_comb begin
    sx  = x0_q[31];
    sg  = g0_q[31];
    lzx = lzc24({1'b0, x0_q[22:0]});
    lzg = lzc24({1'b0, g0_q[22:0]});
    b1_d = '0;
    b1_d.g   = g0_q;
    b1_d.sgn = sx ^ sg;
    if (is_zero(g0_q)) begin
      b1_d.ovr.ovr  = 1'b1;
      b1_d.ovr.bits = (is_zero(x0_q) || is_nan(x0_q)) ? QnanBits
                                                       : {sx ^ sg, 8'hff, 23'h0};
    end
    if (is_nan(x0_q) || is_nan(g0_q) || (is_inf(x0_q) && is_inf(g0_q))) begin
      b1_d.spec      = 1'b1;
      b1_d.spec_bits = QnanBits;
    end else if (is_inf(x0_q)) begin
      b1_d.spec      = 1'b1;
      b1_d.spec_bits = {sx ^ sg, 8'hff, 23'h0};
    end else if (is_inf(g0_q) || is_zero(x0_q)) begin
      b1_d.spec      = 1'b1;
      b1_d.spec_bits = {sx ^ sg, 31'h0};
    end
    if (x0_q[30:23] == 8'h0) begin
      mx1_d = {1'b0, x0_q[22:0]} << lzx;
      ex1_d = sexp_t'(1) - sexp_t'({5'h0, lzx});
    end else begin
      mx1_d = {1'b1, x0_q[22:0]};
      ex1_d = sexp_t'({2'b00, x0_q[30:23]});
    end
    if (g0_q[30:23] == 8'h0) begin
      b1_d.mg = {1'b0, g0_q[22:0]} << lzg;
      eg1_d   = sexp_t'(1) - sexp_t'({5'h0, lzg});
    end else begin
      b1_d.mg = {1'b1, g0_q[22:0]};
      eg1_d   = sexp_t'({2'b00, g0_q[30:23]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p1) begin
      b1_q  <= b1_d;
      mx1_q <= mx1_d;
      ex1_q <= ex1_d;
      eg1_q <= eg1_d;
    end
  end

  // division row
  div_beat_t ch_in, ch_out;
  logic      lt;

  always_comb begin
    lt         = mx1_q < b1_q.mg;
    ch_in      = b1_q;
    ch_in.rem  = lt ? {1'b0, mx1_q, 1'b0} : {2'b00, mx1_q};
    ch_in.quo  = 26'h0;
    ch_in.qexp = ex1_q - eg1_q + sexp_t'(127) - (lt ? sexp_t'(1) : sexp_t'(0));
  end

  msh_div_chain u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_p1_q),
    .ready_o (ch_ready),
    .data_i  (ch_in),
    .valid_o (ch_valid),
    .ready_i (en_r1),
    .data_o  (ch_out)
  );

  // r1: rounded quotient
  logic [31:0] g_r1_q, q_r1_q;
  ovr_t        ovr_r1_q;

  always_ff @(posedge clk_i) begin
    if (en_r1) begin
      g_r1_q   <= ch_out.g;
      ovr_r1_q <= ch_out.ovr;
      q_r1_q   <= ch_out.spec ? ch_out.spec_bits
                              : round_pack(ch_out.sgn, ch_out.qexp,
                                           {ch_out.quo, |ch_out.rem});
    end
  end

  // a1: add specials, swap and align
  logic [31:0] big, sml;
  logic [7:0]  ebig, esml, dsh;
  logic [26:0] bfull, bmask, bal_d;
  logic        spec_a1_d;
  logic [31:0] specb_a1_d;
  logic        spec_a1_q, sgn_a1_q, sub_a1_q;
  logic [31:0] specb_a1_q;
  logic [26:0] a_a1_q, b_a1_q;
  sexp_t       e_a1_q;
  ovr_t        ovr_a1_q;

  always_comb begin
    spec_a1_d  = 1'b1;
    specb_a1_d = 32'h0;
    if (is_nan(g_r1_q) || is_nan(q_r1_q) ||
        (is_inf(g_r1_q) && is_inf(q_r1_q) && (g_r1_q[31] != q_r1_q[31]))) begin
      specb_a1_d = QnanBits;
    end else if (is_inf(g_r1_q)) begin
      specb_a1_d = g_r1_q;
    end else if (is_inf(q_r1_q)) begin
      specb_a1_d = q_r1_q;
    end else if (is_zero(g_r1_q) && is_zero(q_r1_q)) begin
      specb_a1_d = {g_r1_q[31] & q_r1_q[31], 31'h0};
    end else if (is_zero(g_r1_q)) begin
      specb_a1_d = q_r1_q;
    end else if (is_zero(q_r1_q)) begin
      specb_a1_d = g_r1_q;
    end else begin
      spec_a1_d = 1'b0;
    end
    if (g_r1_q[30:0] < q_r1_q[30:0]) begin
      big = q_r1_q;
      sml = g_r1_q;
    end else begin
      big = g_r1_q;
      sml = q_r1_q;
    end
    ebig  = (big[30:23] == 8'h0) ? 8'd1 : big[30:23];
    esml  = (sml[30:23] == 8'h0) ? 8'd1 : sml[30:23];
    dsh   = ebig - esml;
    bfull = {sml[30:23] != 8'h0, sml[22:0], 3'b000};
    bmask = 27'h0;
    if (dsh >= 8'd27) begin
      bal_d = {26'h0, |bfull};
    end else begin
      bmask = (27'h1 << dsh[4:0]) - 27'h1;
      bal_d = (bfull >> dsh[4:0]) | {26'h0, |(bfull & bmask)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a1) begin
      spec_a1_q  <= spec_a1_d;
      specb_a1_q <= specb_a1_d;
      sgn_a1_q   <= big[31];
      sub_a1_q   <= big[31] ^ sml[31];
      a_a1_q     <= {big[30:23] != 8'h0, big[22:0], 3'b000};
      b_a1_q     <= bal_d;
      e_a1_q     <= sexp_t'({2'b00, ebig});
      ovr_a1_q   <= ovr_r1_q;
    end
  end

  // a2: mantissa add
  logic        spec_a2_q, sgn_a2_q;
  logic [31:0] specb_a2_q;
  logic [27:0] s_a2_q;
  sexp_t       e_a2_q;
  ovr_t        ovr_a2_q;

  always_ff @(posedge clk_i) begin
    if (en_a2) begin
      spec_a2_q  <= spec_a1_q;
      specb_a2_q <= specb_a1_q;
      sgn_a2_q   <= sgn_a1_q;
      e_a2_q     <= e_a1_q;
      ovr_a2_q   <= ovr_a1_q;
      s_a2_q     <= sub_a1_q ? ({1'b0, a_a1_q} - {1'b0, b_a1_q})
                             : ({1'b0, a_a1_q} + {1'b0, b_a1_q});
    end
  end

  // a3: normalise
  logic [4:0]  lzs;
  logic [26:0] m_a3_d;
  sexp_t       e_a3_d;
  logic        spec_a3_q, sgn_a3_q, zero_a3_q;
  logic [31:0] specb_a3_q;
  logic [26:0] m_a3_q;
  sexp_t       e_a3_q;
  ovr_t        ovr_a3_q;

  always_comb begin
    lzs = lzc27(s_a2_q[26:0]);
    if (s_a2_q[27]) begin
      m_a3_d = {s_a2_q[27:2], s_a2_q[1] | s_a2_q[0]};
      e_a3_d = e_a2_q + sexp_t'(1);
    end else begin
      m_a3_d = s_a2_q[26:0] << lzs;
      e_a3_d = e_a2_q - sexp_t'({5'h0, lzs});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a3) begin
      spec_a3_q  <= spec_a2_q;
      specb_a3_q <= specb_a2_q;
      sgn_a3_q   <= sgn_a2_q;
      zero_a3_q  <= s_a2_q == 28'h0;
      m_a3_q     <= m_a3_d;
      e_a3_q     <= e_a3_d;
      ovr_a3_q   <= ovr_a2_q;
    end
  end

  // a4: rounded sum
  logic [31:0] s_a4_q;
  ovr_t        ovr_a4_q;

  always_ff @(posedge clk_i) begin
    if (en_a4) begin
      ovr_a4_q <= ovr_a3_q;
      if (spec_a3_q) begin
        s_a4_q <= specb_a3_q;
      end else if (zero_a3_q) begin
        s_a4_q <= 32'h0;
      end else begin
        s_a4_q <= round_pack(sgn_a3_q, e_a3_q, m_a3_q);
      end
    end
  end

  // h1: unpack sum for halving
  logic [4:0]  lzh;
  logic [23:0] m_h1_d;
  sexp_t       e_h1_d;
  logic        spec_h1_q, sgn_h1_q;
  logic [31:0] specb_h1_q;
  logic [23:0] m_h1_q;
  sexp_t       e_h1_q;
  ovr_t        ovr_h1_q;

  always_comb begin
    lzh = lzc24({1'b0, s_a4_q[22:0]});
    if (s_a4_q[30:23] == 8'h0) begin
      m_h1_d = {1'b0, s_a4_q[22:0]} << lzh;
      e_h1_d = sexp_t'(0) - sexp_t'({5'h0, lzh});
    end else begin
      m_h1_d = {1'b1, s_a4_q[22:0]};
      e_h1_d = sexp_t'({2'b00, s_a4_q[30:23]}) - sexp_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_h1) begin
      spec_h1_q  <= is_nan(s_a4_q) || is_inf(s_a4_q) || is_zero(s_a4_q);
      specb_h1_q <= is_nan(s_a4_q) ? QnanBits : s_a4_q;
      sgn_h1_q   <= s_a4_q[31];
      m_h1_q     <= m_h1_d;
      e_h1_q     <= e_h1_d;
      ovr_h1_q   <= ovr_a4_q;
    end
  end

  // h2: halved result, output register
  logic [31:0] r_h2_d, r_h2_q;
  logic        ovr_h2_q;

  always_comb begin
    if (ovr_h1_q.ovr) begin
      r_h2_d = ovr_h1_q.bits;
    end else if (spec_h1_q) begin
      r_h2_d = specb_h1_q;
    end else begin
      r_h2_d = round_pack(sgn_h1_q, e_h1_q, {m_h1_q, 3'b000});
    end
    if (is_nan(r_h2_d)) begin
      r_h2_d = QnanBits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_h2) begin
      r_h2_q   <= r_h2_d;
      ovr_h2_q <= ovr_h1_q.ovr;
    end
  end

  assign out_valid_o = v_h2_q;
  assign root_bits_o = r_h2_q;

  // checks
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v_p0_q && v_p1_q))
    else $error("input stalled with an empty front stage");

  a_nan_canon : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_nan(root_bits_o)) |-> (root_bits_o == QnanBits))
    else $error("non-canonical nan on output");

  a_zero_guess : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ovr_h2_q) |-> (root_bits_o[30:23] == 8'hff))
    else $error("zero guess result is neither infinity nor nan");

endmodule

/* bench/tb_magic_sqrt_heron_step.sv */
// ----------------------------------------------------------------------------
// tb_magic_sqrt_heron_step: self-checking bench for the magic square root
// A directed table and then a random stream of single-precision patterns
// drive the block under several magic words, with random gaps and output
// stalls. Each result beat is checked against an in-bench single-precision
// model of the guess and one Heron step.
// ----------------------------------------------------------------------------
module tb_magic_sqrt_heron_step;
  import msh_pkg::*;

  localparam int          NumRandom  = 650;
  localparam int          DrainWait  = 60;
  localparam logic [31:0] PosInf     = 32'h7F800000;
  localparam logic [31:0] NegInf     = 32'hFF800000;
  localparam logic [31:0] NoCheck    = 32'h0;

  typedef struct {
    logic [31:0] magic;
    logic [31:0] value;
    logic        typed;
    logic [31:0] root;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] value_bits_i = 32'h0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] root_bits_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] magic_now = MagicReset;
  logic [31:0] root_q[$];
  logic        typed_q[$];
  logic [31:0] typed_root_q[$];
  logic        next_typed = 1'b0;
  logic [31:0] next_root = 32'h0;
  int          n_bad = 0;
  int          n_beats = 0;
  int          n_sent = 0;
  int          n_magic = 0;
  bit          stall_calm = 1'b0;

  always #10 clk_i = ~clk_i;

  magic_sqrt_heron_step DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .value_bits_i,
    .out_valid_o, .out_stall_i, .root_bits_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // single float pattern widened to a real, exact
  function automatic real widen(input logic [31:0] b);
    logic [63:0] d;
    real         v;
    if (b[30:23] == 8'hff) begin
      d = {b[31], 11'h7ff, b[22:0], 29'h0};
      return $bitstoreal(d);
    end
    if (b[30:23] == 8'h0) begin
      v = real'(b[22:0]) * (2.0 ** -149);
      return b[31] ? -v : v;
    end
    d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'h0};
    return $bitstoreal(d);
  endfunction

  // real to single pattern, round to nearest even, subnormals kept
  function automatic logic [31:0] narrow(input real v);
    logic [63:0] d;
    longint      ue;
    longint      sh;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] body;
    d = $realtobits(v);
    if (d[62:52] == 11'h7ff) begin
      if (d[51:0] != 52'h0) return QnanBits;
      return {d[63], 8'hff, 23'h0};
    end
    if (d[62:52] == 11'h0) return {d[63], 31'h0};
    ue = longint'(d[62:52]) - 1023 + 127;
    if (ue > 254) return {d[63], 8'hff, 23'h0};
    sig = {11'h0, 1'b1, d[51:0]};
    sh = (ue >= 1) ? 29 : 29 + (1 - ue);
    if (sh > 60) return {d[63], 31'h0};
    kept = sig >> sh;
    rem  = sig & ((64'h1 << sh) - 64'h1);
    half = 64'h1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'h1;
    body = (ue >= 1) ? ((64'(ue - 1) << 23) + kept) : kept;
    if (body >= 64'h7F800000) return {d[63], 8'hff, 23'h0};
    return {d[63], body[30:0]};
  endfunction

  function automatic logic [31:0] heron_root(input logic [31:0] x,
                                              input logic [31:0] magic);
    logic [31:0] guess;
    logic [31:0] quot;
    logic [31:0] sum;
    logic [31:0] r;
    guess = {x[31], x[31:1]} + magic;
    if (guess[30:0] == 31'h0) begin
      if (x[30:0] == 31'h0 || (x[30:23] == 8'hff && x[22:0] != 23'h0)) return QnanBits;
      return {x[31] ^ guess[31], 8'hff, 23'h0};
    end
    quot = narrow(widen(x) / widen(guess));
    sum  = narrow(widen(guess) + widen(quot));
    r    = narrow(0.5 * widen(sum));
    if (r[30:23] == 8'hff && r[22:0] != 23'h0) return QnanBits;
    return r;
  endfunction

  function automatic int gap_len();
    int u;
    u = $urandom_range(0, 99);
    if (u < 60) return 0;
    if (u < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      root_q.push_back(heron_root(value_bits_i, magic_now));
      typed_q.push_back(next_typed);
      typed_root_q.push_back(next_root);
      n_sent++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_beats++;
      if (root_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat root=%h", root_bits_o);
      end else begin
        if (root_bits_o !== root_q[0] ||
            (typed_q[0] && root_bits_o !== typed_root_q[0])) begin
          n_bad++;
          if (n_bad <= 10)
            $display("root mismatch: expected %h (table %h) got %h",
                     root_q[0], typed_q[0] ? typed_root_q[0] : root_q[0],
                     root_bits_o);
        end
        void'(root_q.pop_front());
        void'(typed_q.pop_front());
        void'(typed_root_q.pop_front());
      end
    end
  end

  // output stall, with calm stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_calm = ~stall_calm;
    if (stall_calm) begin
      out_stall_i = 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      out_stall_i = 1'b1;
      repeat ($urandom_range(8, 30)) @(negedge clk_i);
      out_stall_i = 1'b0;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < 20);
    end
  end

  task automatic send_value(input logic [31:0] v, input logic typed, input logic [31:0] r);
    int g;
    g = stall_calm ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      value_bits_i = $urandom();
      repeat (g) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    value_bits_i = v;
    next_typed = typed;
    next_root = r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (root_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_magic(input logic [31:0] m);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = AddrMagic; pwdata = m;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    magic_now = m;
    n_magic++;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    pwrite = 1'b0; psel = 1'b1; paddr = AddrMagic;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== m) begin
      n_bad++;
      if (n_bad <= 10) $display("magic_word readback: expected %h got %h", m, prdata);
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    int          u;
    logic [31:0] v;
    u = $urandom_range(0, 99);
    v = $urandom();
    if (u < 45) v[31] = 1'b0;
    else if (u < 55) v[30:23] = 8'h0;
    else if (u < 62) v = {v[31], 8'hff, (v[0] ? 23'h0 : v[22:0])};
    else if (u < 68) v = {v[31], 31'h0};
    return v;
  endfunction

  stim_row_t stim_table[] = '{
    '{MagicReset, 32'h7FC00000, 1'b1, QnanBits},
    '{MagicReset, 32'hFFFFFFFF, 1'b1, QnanBits},
    '{MagicReset, 32'h7F800001, 1'b1, QnanBits},
    '{MagicReset, PosInf,       1'b1, PosInf},
    '{MagicReset, NegInf,       1'b0, NoCheck},
    '{MagicReset, 32'h00000000, 1'b0, NoCheck},
    '{MagicReset, 32'h80000000, 1'b0, NoCheck},
    '{MagicReset, 32'h3F800000, 1'b0, NoCheck},
    '{MagicReset, 32'h40800000, 1'b0, NoCheck},
    '{MagicReset, 32'hBF800000, 1'b0, NoCheck},
    '{MagicReset, 32'h00000001, 1'b0, NoCheck},
    '{MagicReset, 32'h007FFFFF, 1'b0, NoCheck},
    '{MagicReset, 32'h00800000, 1'b0, NoCheck},
    '{MagicReset, 32'h7F7FFFFF, 1'b0, NoCheck},
    '{MagicReset, 32'h80000001, 1'b0, NoCheck},
    '{32'h00000000, 32'h00000000, 1'b1, QnanBits},
    '{32'h00000000, 32'h00000001, 1'b1, PosInf},
    '{32'h00000000, 32'h3F800000, 1'b0, NoCheck},
    '{32'h40000000, 32'h80000001, 1'b1, NegInf},
    '{32'h40000000, 32'h80000000, 1'b1, QnanBits},
    '{32'hFFFFFFFF, 32'h00000002, 1'b0, NoCheck},
    '{32'hFFFFFFFF, 32'h7F7FFFFF, 1'b0, NoCheck},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, QnanBits}
  };

  logic [31:0] magic_set[] = '{MagicReset, 32'h5F3759DF, 32'h00000000,
                               32'hFFFFFFFF, 32'h1FBD1DF5};

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (stim_table[i]) begin
      if (stim_table[i].magic !== magic_now) begin
        drain();
        write_magic(stim_table[i].magic);
      end
      send_value(stim_table[i].value, stim_table[i].typed, stim_table[i].root);
    end
    for (int p = 0; p < 6; p++) begin
      drain();
      write_magic(p < 5 ? magic_set[p] : $urandom());
      for (int k = 0; k < NumRandom / 6; k++) send_value(rand_value(), 1'b0, NoCheck);
    end
    drain();
    $display("%0d operands sent, %0d result beats checked, %0d magic word writes",
             n_sent, n_beats, n_magic);
    if (n_bad == 0 && root_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", n_bad, root_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
